// ----- hw/rtl/krt_pkg.sv -----
//------------------------------------------------------------------------------
// krt_pkg
// Shared types and codes for the keyed record table: request and response
// items, the record held in each cell, request and status codes.
//------------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;
  localparam logic [1:0] REQ_DUMP   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUP_KEY   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] part_key;
    logic signed [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic signed [31:0] quantity;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] qty;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/krt_cell.sv -----
//------------------------------------------------------------------------------
// krt_cell
// One record slot of the ring: holds a key and a quantity and passes them to
// the next cell on every shift.
//------------------------------------------------------------------------------
`default_nettype none

module krt_cell (
  input  wire logic            clk,
  input  wire logic            shift,
  input  wire krt_pkg::entry_t d,
  output krt_pkg::entry_t      q
);

  krt_pkg::entry_t rec;

  always_ff @(posedge clk) begin
    if (shift) begin
      rec <= d;
    end
  end

  assign q = rec;

endmodule

`default_nettype wire

// ----- hw/rtl/krt_ctrl.sv -----
//------------------------------------------------------------------------------
// krt_ctrl
// Head unit of the ring: walks the records as they leave the last cell,
// places inserts in key order, applies updates, and drives the response item.
//------------------------------------------------------------------------------
`default_nettype none

module krt_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire krt_pkg::req_t   req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output krt_pkg::rsp_t        rsp,
  input  wire krt_pkg::entry_t head,
  output krt_pkg::entry_t      feed,
  output logic                 shift
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_DONE = 4'b0100,
    S_DUMP = 4'b1000
  } st_t;

  st_t                state;
  logic [1:0]         op;
  logic signed [31:0] key_r;
  logic signed [31:0] amt_r;
  logic [IW-1:0]      idx;
  logic [CW-1:0]      count;
  logic               found;
  logic               placed;
  logic               carrying;
  logic               walked;
  krt_pkg::entry_t    carry;
  logic [2:0]         res_status;
  logic signed [31:0] res_qty;
  krt_pkg::rsp_t      out_r;
  logic               out_valid;

  logic               live;
  logic               match;
  logic               greater;
  logic               walk_end;
  logic               slot_free;
  logic               out_load;
  logic signed [32:0] sum;
  logic signed [31:0] sat;
  krt_pkg::rsp_t      done_rsp;

  assign live      = CW'(idx) < count;
  assign match     = live && (head.key == key_r);
  assign greater   = $signed(head.key) > $signed(key_r);
  assign walk_end  = idx == IW'(DEPTH - 1);
  assign slot_free = !out_valid || rsp_ready;
  assign out_load  = (state == S_DONE && slot_free) || (state == S_DUMP && live && slot_free);
  assign sum       = {head.qty[31], head.qty} + {amt_r[31], amt_r};

  always_comb begin
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
  end

  always_comb begin
    done_rsp.last    = 1'b1;
    done_rsp.out_key = (op == krt_pkg::REQ_DUMP) ? 32'sd0 : key_r;
    if (!walked) begin
      done_rsp.status = res_status;
    end else if (op == krt_pkg::REQ_INSERT) begin
      done_rsp.status = placed ? krt_pkg::ST_OK : krt_pkg::ST_DUP_KEY;
    end else begin
      done_rsp.status = found ? krt_pkg::ST_OK : krt_pkg::ST_NOT_FOUND;
    end
    if (walked && op == krt_pkg::REQ_INSERT && placed) begin
      done_rsp.quantity = amt_r;
    end else if (walked && found) begin
      done_rsp.quantity = res_qty;
    end else begin
      done_rsp.quantity = 32'sd0;
    end
  end

  always_comb begin
    shift = 1'b0;
    feed  = head;
    unique case (state)
      S_WALK: begin
        shift = 1'b1;
        if (op == krt_pkg::REQ_INSERT) begin
          if (carrying) begin
            feed = carry;
          end else if (!found && !placed && !match && (!live || greater)) begin
            feed.key = key_r;
            feed.qty = amt_r;
          end
        end else if (op == krt_pkg::REQ_UPDATE && match) begin
          feed.qty = sat;
        end
      end
      S_DUMP: begin
        shift = live ? slot_free : 1'b1;
      end
      default: begin
        shift = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req.req_type;
            key_r      <= req.part_key;
            amt_r      <= req.amount;
            idx        <= '0;
            found      <= 1'b0;
            placed     <= 1'b0;
            carrying   <= 1'b0;
            walked     <= 1'b0;
            res_qty    <= 32'sd0;
            if (req.req_type == krt_pkg::REQ_INSERT && count == CW'(DEPTH)) begin
              res_status <= krt_pkg::ST_FULL;
              state      <= S_DONE;
            end else if (req.req_type == krt_pkg::REQ_DUMP && count == '0) begin
              res_status <= krt_pkg::ST_EMPTY;
              state      <= S_DONE;
            end else if (req.req_type == krt_pkg::REQ_DUMP) begin
              res_status <= krt_pkg::ST_OK;
              state      <= S_DUMP;
            end else begin
              res_status <= krt_pkg::ST_OK;
              state      <= S_WALK;
            end
          end
        end
        S_WALK: begin
          idx <= idx + IW'(1);
          if (op == krt_pkg::REQ_INSERT) begin
            if (carrying) begin
              carry <= head;
            end else if (!found && !placed) begin
              if (match) begin
                found   <= 1'b1;
                res_qty <= head.qty;
              end else if (!live || greater) begin
                placed   <= 1'b1;
                carrying <= 1'b1;
                carry    <= head;
              end
            end
          end else if (match) begin
            found   <= 1'b1;
            res_qty <= (op == krt_pkg::REQ_UPDATE) ? sat : head.qty;
          end
          if (walk_end) begin
            walked <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_r <= done_rsp;
            state <= S_IDLE;
            if (walked && op == krt_pkg::REQ_INSERT && placed) begin
              count <= count + CW'(1);
            end
          end
        end
        S_DUMP: begin
          if (shift) begin
            idx <= idx + IW'(1);
            if (live) begin
              out_r.status   <= krt_pkg::ST_OK;
              out_r.out_key  <= head.key;
              out_r.quantity <= head.qty;
              out_r.last     <= CW'(idx) == count - CW'(1);
            end
            if (walk_end) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready = state == S_IDLE;
  assign rsp_valid = out_valid;
  assign rsp       = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_record_table.sv -----
//------------------------------------------------------------------------------
// keyed_record_table
// Table of signed key / quantity records kept in ascending key order in a
// ring of cells; insert, search, update and sorted dump of all records.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | krt_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready | krt_pkg::rsp_t
//
// Insert, search and update rotate the ring once, the head unit taking one
// record per cycle, and then register the response item.
// Insert into a full table and dump of an empty table answer without rotating the ring.
// A dump rotates the ring once, holding a live record while the response slot is full.
// Reset clears the fill count and control; record contents need no reset.
//------------------------------------------------------------------------------
`default_nettype none

module keyed_record_table #(
  parameter int DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire krt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output krt_pkg::rsp_t      rsp
);

  krt_pkg::entry_t ring [DEPTH];
  krt_pkg::entry_t feed;
  logic            shift;

  krt_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (ring[DEPTH-1]),
    .feed      (feed),
    .shift     (shift)
  );

  krt_cell u_cell0 (
    .clk   (clk),
    .shift (shift),
    .d     (feed),
    .q     (ring[0])
  );

  for (genvar i = 1; i < DEPTH; i++) begin : g_cell
    krt_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (ring[i-1]),
      .q     (ring[i])
    );
  end

endmodule

`default_nettype wire
